/* hdl/byte_ring_buffer_burst_macros.svh */
`ifndef BYTE_RING_BUFFER_BURST_MACROS_SVH
`define BYTE_RING_BUFFER_BURST_MACROS_SVH

// same-cycle implication, checks off while reset is low
`define BRB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/brb_pkg.sv */
`default_nettype none

package brb_pkg;

    localparam int DEPTH     = 256;
    localparam int MAX_BURST = 8;
    localparam int LANES     = 8;
    localparam int LANE_W    = 3;
    localparam int ROWS      = DEPTH / LANES;
    localparam int ROW_W     = 5;
    localparam int PTR_W     = 8;
    localparam int CAP_W     = 9;
    localparam int LEN_W     = 4;
    localparam int BYTE_W    = 8;
    localparam int DATA_W    = 64;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic CMD_WRITE    = 1'b0;
    localparam logic CMD_READ     = 1'b1;
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(DEPTH);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEG0,
        S_SEG1,
        S_DRAIN
    } t_state;

    // one contiguous run of ring slots, handed to every lane
    typedef struct packed {
        logic              go;
        logic              wr;
        logic              rd;
        logic [PTR_W-1:0]  start;
        logic [LEN_W-1:0]  count;
        logic [LEN_W-1:0]  offset;
    } t_seg;

    // what a lane read: its byte and where it goes in the beat
    typedef struct packed {
        logic              act;
        logic [LANE_W-1:0] idx;
        logic [BYTE_W-1:0] data;
    } t_lane_rd;

endpackage

`default_nettype wire

/* hdl/byte_ring_buffer_burst.sv */
// Byte ring buffer taking bursts of 0 to 8 bytes per beat, packed first byte in bits 7..0.
// Storage is eight byte-wide banks of 32 rows; slot p lives in bank p mod 8, so a run of
// up to eight consecutive slots touches each bank at most once. A burst that wraps past
// the end of the ring takes longer to finish, because the part after the wrap needs a
// second pass through the banks; the input is ready again as the result is loaded. A
// finished result sits in an output register, so the next burst is taken while it waits;
// a result still waiting when the following one is done holds the input off until it is
// taken. Writing capacity (register 0, 1..256, zero acts as 1, more as 256) empties the
// ring; write it only while idle. Bytes are only ever read from slots a write filled.
`default_nettype none

`include "byte_ring_buffer_burst_macros.svh"

module byte_ring_buffer_burst
    import brb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_cmd,
    input  wire logic [LEN_W-1:0]  i_length,
    input  wire logic [DATA_W-1:0] i_write_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_accepted,
    output logic [DATA_W-1:0]      o_read_data,
    output logic [CAP_W-1:0]       o_level,
    output logic                   o_is_full
);

    t_state            r_state, n_state;
    logic [CAP_W-1:0]  r_cap;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic              r_full, n_full;

    logic              r_cmd;
    logic              r_ok, n_ok;
    logic [PTR_W-1:0]  r_base;
    logic [LEN_W-1:0]  r_n0, n_n0;
    logic [LEN_W-1:0]  r_n1, n_n1;
    logic [DATA_W-1:0] r_wdata;
    logic [DATA_W-1:0] r_acc;

    logic              r_ovalid;
    logic              r_oacc;
    logic [DATA_W-1:0] r_odata;
    logic [CAP_W-1:0]  r_olevel;
    logic              r_ofull;

    logic              cfg_wr;
    logic              accept;
    logic              load_out;
    logic              merge_en;
    logic [CAP_W-1:0]  cap;
    logic [CAP_W-1:0]  occ;
    logic [CAP_W-1:0]  free_cnt;
    logic [PTR_W-1:0]  base;
    logic [CAP_W-1:0]  room;
    logic [CAP_W-1:0]  sum;
    logic [PTR_W-1:0]  new_ptr;
    t_seg              seg;
    t_lane_rd [LANES-1:0] lane_rd;
    logic [DATA_W-1:0] merged;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1] == REG_CAPACITY);
    assign prdata = (paddr[APB_AW-1] == REG_CAPACITY) ? APB_DW'(r_cap) : '0;

    // ---------------- occupancy and decode ----------------
    always_comb begin
        cap = r_cap;
        if (r_cap == '0) begin
            cap = CAP_W'(1);
        end else if (r_cap > CAP_MAX) begin
            cap = CAP_MAX;
        end

        if (r_full) begin
            occ = cap;
        end else if (r_wp >= r_rp) begin
            occ = {1'b0, r_wp} - {1'b0, r_rp};
        end else begin
            occ = cap + {1'b0, r_wp} - {1'b0, r_rp};
        end
        free_cnt = cap - occ;

        n_ok = 1'b0;
        if (i_length <= LEN_W'(MAX_BURST)) begin
            if (i_cmd == CMD_WRITE) begin
                n_ok = CAP_W'(i_length) <= free_cnt;
            end else begin
                n_ok = CAP_W'(i_length) <= occ;
            end
        end

        base = (i_cmd == CMD_READ) ? r_rp : r_wp;
        room = cap - {1'b0, base};
        // for an accepted burst it stays below twice the capacity, one subtract wraps it
        sum  = {1'b0, base} + CAP_W'(i_length);
        if (sum >= cap) begin
            new_ptr = PTR_W'(sum - cap);
        end else begin
            new_ptr = sum[PTR_W-1:0];
        end

        n_n0 = '0;
        n_n1 = '0;
        if (n_ok) begin
            if (CAP_W'(i_length) <= room) begin
                n_n0 = i_length;
            end else begin
                n_n0 = room[LEN_W-1:0];
            end
            n_n1 = i_length - n_n0;
        end

        n_rp   = r_rp;
        n_wp   = r_wp;
        n_full = r_full;
        if (n_ok && (i_length != '0)) begin
            if (i_cmd == CMD_WRITE) begin
                n_wp = new_ptr;
                if (new_ptr == r_rp) begin
                    n_full = 1'b1;
                end
            end else begin
                n_rp   = new_ptr;
                n_full = 1'b0;
            end
        end
    end

    // ---------------- control ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_SEG0;
                end
            end
            S_SEG0: begin
                n_state = (r_n1 != '0) ? S_SEG1 : S_DRAIN;
            end
            S_SEG1: begin
                n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!r_ovalid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready    = 1'b0;
        load_out   = 1'b0;
        merge_en   = 1'b0;
        seg.go     = 1'b0;
        seg.wr     = (r_cmd == CMD_WRITE);
        seg.rd     = (r_cmd == CMD_READ);
        seg.start  = r_base;
        seg.count  = r_n0;
        seg.offset = '0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
            end
            S_SEG0: begin
                seg.go = 1'b1;
            end
            S_SEG1: begin
                // second run restarts at slot zero after the wrap
                seg.go     = 1'b1;
                seg.start  = '0;
                seg.count  = r_n1;
                seg.offset = r_n0;
                merge_en   = 1'b1;
            end
            S_DRAIN: begin
                merge_en = 1'b1;
                load_out = !r_ovalid || i_ready;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap   <= CAP_RESET;
            r_rp    <= '0;
            r_wp    <= '0;
            r_full  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_cap  <= pwdata[CAP_W-1:0];
                r_rp   <= '0;
                r_wp   <= '0;
                r_full <= 1'b0;
            end else if (accept) begin
                r_rp   <= n_rp;
                r_wp   <= n_wp;
                r_full <= n_full;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_cmd;
            r_ok    <= n_ok;
            r_base  <= base;
            r_n0    <= n_n0;
            r_n1    <= n_n1;
            r_wdata <= i_write_data;
            r_acc   <= '0;
        end else if (merge_en) begin
            r_acc <= merged;
        end
    end

    // ---------------- byte lanes ----------------
    for (genvar b = 0; b < LANES; b++) begin : g_lane
        brb_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_bank       (LANE_W'(b)),
            .i_seg        (seg),
            .i_write_data (r_wdata),
            .o_rd         (lane_rd[b])
        );
    end

    brb_merge u_merge (
        .i_lanes (lane_rd),
        .i_acc   (r_acc),
        .o_data  (merged)
    );

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // pointers already hold this beat's update, so occ is the level after it
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_oacc   <= r_ok;
            r_odata  <= merged;
            r_olevel <= occ;
            r_ofull  <= r_full;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_accepted  = r_oacc;
    assign o_read_data = r_odata;
    assign o_level     = r_olevel;
    assign o_is_full   = r_ofull;

    // ---------------- checks ----------------
    `BRB_ASSERT_IMPL(a_wp_range, i_clk, i_rst_n, 1'b1, ({1'b0, r_wp} < cap), "write pointer past capacity")
    `BRB_ASSERT_IMPL(a_full_ptrs, i_clk, i_rst_n, r_full, (r_wp == r_rp), "full with pointers apart")
    `BRB_ASSERT_IMPL(a_seg_len, i_clk, i_rst_n, (r_state == S_SEG0), ((r_n0 + r_n1) <= LEN_W'(MAX_BURST)), "burst split too long")
    `BRB_ASSERT_NEXT(a_accept_seq, i_clk, i_rst_n, accept && !cfg_wr, (r_state == S_SEG0), "accepted beat did not start")

endmodule

`default_nettype wire

/* hdl/brb_lane.sv */
`default_nettype none

module brb_lane
    import brb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [LANE_W-1:0] i_bank,
    input  wire t_seg              i_seg,
    input  wire logic [DATA_W-1:0] i_write_data,
    output t_lane_rd               o_rd
);

    logic [BYTE_W-1:0] r_mem [ROWS];
    logic [BYTE_W-1:0] r_q;
    logic              r_act;
    logic [LANE_W-1:0] r_idx;

    logic [LANE_W-1:0] k;
    logic              active;
    logic [LANE_W-1:0] idx;
    logic [CAP_W-1:0]  pos;
    logic [ROW_W-1:0]  row;

    // slot start+k is the one of this run that falls in this bank
    always_comb begin
        k      = i_bank - i_seg.start[LANE_W-1:0];
        active = i_seg.go && ({1'b0, k} < i_seg.count);
        idx    = k + i_seg.offset[LANE_W-1:0];
        pos    = {1'b0, i_seg.start} + CAP_W'(k);
        row    = pos[PTR_W-1:LANE_W];
    end

    always_ff @(posedge i_clk) begin
        if (active && i_seg.wr) begin
            r_mem[row] <= i_write_data[{idx, 3'b000} +: BYTE_W];
        end
        if (active && i_seg.rd) begin
            r_q <= r_mem[row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_idx <= '0;
        end else if (i_seg.go) begin
            r_act <= active && i_seg.rd;
            r_idx <= idx;
        end
    end

    assign o_rd.act  = r_act;
    assign o_rd.idx  = r_idx;
    assign o_rd.data = r_q;

endmodule

`default_nettype wire

/* hdl/brb_merge.sv */
`default_nettype none

module brb_merge
    import brb_pkg::*;
(
    input  wire t_lane_rd [LANES-1:0] i_lanes,
    input  wire logic [DATA_W-1:0]    i_acc,
    output logic [DATA_W-1:0]         o_data
);

    // each beat byte takes the lane that claims it, else keeps what it had
    always_comb begin
        o_data = i_acc;
        for (int j = 0; j < LANES; j++) begin
            for (int b = 0; b < LANES; b++) begin
                if (i_lanes[b].act && (i_lanes[b].idx == LANE_W'(j))) begin
                    o_data[j*BYTE_W +: BYTE_W] = i_lanes[b].data;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* tb/byte_ring_buffer_burst_tb.sv */
`timescale 1ns / 1ps

module byte_ring_buffer_burst_tb;
    import brb_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int PHASES      = 10;
    localparam int PHASE_BEATS = 50;
    localparam int CHUNK       = 20;
    localparam int PLAN_ROWS   = 20;
    localparam logic [APB_AW-1:0] CAPACITY_ADDR = APB_AW'(4 * REG_CAPACITY);

    typedef struct packed {
        logic              accepted;
        logic [DATA_W-1:0] read_data;
        logic [CAP_W-1:0]  level;
        logic              is_full;
    } burst_result_t;

    typedef struct packed {
        logic              cmd;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] wdata;
        logic              typed;
        burst_result_t     want;
    } plan_row_t;

    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } traffic_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              i_valid;
    logic              o_ready;
    logic              i_cmd;
    logic [LEN_W-1:0]  i_length;
    logic [DATA_W-1:0] i_write_data;
    logic              o_valid;
    logic              i_ready;
    logic              o_accepted;
    logic [DATA_W-1:0] o_read_data;
    logic [CAP_W-1:0]  o_level;
    logic              o_is_full;

    // ring predictor state
    logic [BYTE_W-1:0] ring_bytes [DEPTH];
    int                head_ptr;
    int                tail_ptr;
    logic              ring_full;
    logic [CAP_W-1:0]  capacity_reg;

    burst_result_t     pending_results [$];
    int                mismatches;
    int                results_seen;
    int                stall_cycles;
    int                gap_odds;
    logic              calm;

    plan_row_t opening_plan [PLAN_ROWS] = '{
        '{CMD_READ,  4'd0,  64'd0, 1'b1, '{1'b1, 64'd0, 9'd0, 1'b0}},
        '{CMD_READ,  4'd1,  64'd0, 1'b1, '{1'b0, 64'd0, 9'd0, 1'b0}},
        '{CMD_WRITE, 4'd9,  {64{1'b1}}, 1'b1, '{1'b0, 64'd0, 9'd0, 1'b0}},
        '{CMD_WRITE, 4'd15, {64{1'b1}}, 1'b1, '{1'b0, 64'd0, 9'd0, 1'b0}},
        '{CMD_READ,  4'd15, 64'd0, 1'b1, '{1'b0, 64'd0, 9'd0, 1'b0}},
        '{CMD_WRITE, 4'd0,  {64{1'b1}}, 1'b1, '{1'b1, 64'd0, 9'd0, 1'b0}},
        '{CMD_WRITE, 4'd8,  {64{1'b1}}, 1'b1, '{1'b1, 64'd0, 9'd8, 1'b0}},
        '{CMD_WRITE, 4'd8,  64'd0, 1'b1, '{1'b1, 64'd0, 9'd16, 1'b0}},
        '{CMD_READ,  4'd8,  64'd0, 1'b1, '{1'b1, {64{1'b1}}, 9'd8, 1'b0}},
        '{CMD_WRITE, 4'd8,  64'h5555_5555_5555_5555, 1'b0, '0},
        '{CMD_WRITE, 4'd8,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
        '{CMD_READ,  4'd3,  64'd0, 1'b0, '0},
        '{CMD_WRITE, 4'd1,  64'h0123_4567_89AB_CD5A, 1'b0, '0},
        '{CMD_READ,  4'd9,  64'd0, 1'b0, '0},
        '{CMD_READ,  4'd8,  64'd0, 1'b0, '0},
        '{CMD_READ,  4'd8,  64'd0, 1'b0, '0},
        '{CMD_READ,  4'd8,  64'd0, 1'b0, '0},
        '{CMD_WRITE, 4'd14, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
        '{CMD_READ,  4'd6,  64'd0, 1'b0, '0},
        '{CMD_READ,  4'd1,  64'd0, 1'b0, '0}
    };

    byte_ring_buffer_burst dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_length     (i_length),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_accepted   (o_accepted),
        .o_read_data  (o_read_data),
        .o_level      (o_level),
        .o_is_full    (o_is_full)
    );

    always #5 i_clk = ~i_clk;

    function automatic int ring_span();
        int span;
        span = int'(capacity_reg);
        if (span == 0) span = 1;
        if (span > DEPTH) span = DEPTH;
        return span;
    endfunction

    function automatic int ring_level(input int span);
        int used;
        used = (ring_full ? span : 0) + tail_ptr - head_ptr;
        if (tail_ptr < head_ptr) used += span;
        return used;
    endfunction

    // one burst through the ring, result as the block should report it
    task automatic ring_burst(input logic cmd, input logic [LEN_W-1:0] len,
                              input logic [DATA_W-1:0] wdata, output burst_result_t res);
        int span;
        int used;
        int n;
        int k;
        span = ring_span();
        used = ring_level(span);
        n    = int'(len);
        res  = '0;
        if (n <= MAX_BURST) begin
            if (cmd == CMD_WRITE) begin
                if (n <= span - used) begin
                    res.accepted = 1'b1;
                    for (k = 0; k < n; k++)
                        ring_bytes[(tail_ptr + k) % span] = wdata[8*k +: 8];
                    tail_ptr = (tail_ptr + n) % span;
                    if (n > 0 && tail_ptr == head_ptr) ring_full = 1'b1;
                end
            end else if (n <= used) begin
                res.accepted = 1'b1;
                for (k = 0; k < n; k++)
                    res.read_data[8*k +: 8] = ring_bytes[(head_ptr + k) % span];
                head_ptr = (head_ptr + n) % span;
                if (n > 0) ring_full = 1'b0;
            end
        end
        res.level   = CAP_W'(ring_level(span));
        res.is_full = ring_full;
    endtask

    // offer one beat, predict at acceptance, then maybe go quiet for a while
    task automatic offer_burst(input logic cmd, input logic [LEN_W-1:0] len,
                               input logic [DATA_W-1:0] wdata, input logic typed,
                               input burst_result_t want);
        burst_result_t res;
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_length     <= len;
        i_write_data <= wdata;
        do @(posedge i_clk); while (!o_ready);
        ring_burst(cmd, len, wdata, res);
        pending_results.push_back(typed ? want : res);
        if (gap_odds > 0 && $urandom_range(1, gap_odds) == 1) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        if (i_valid) i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        capacity_reg = value[CAP_W-1:0];
        head_ptr     = 0;
        tail_ptr     = 0;
        ring_full    = 1'b0;
    endtask

    task automatic random_burst(input traffic_t mode);
        logic              cmd;
        logic [LEN_W-1:0]  len;
        int                pick;
        pick = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:  cmd = (pick < 85) ? CMD_WRITE : CMD_READ;
            MODE_DRAIN: cmd = (pick < 85) ? CMD_READ : CMD_WRITE;
            default:    cmd = (pick < 50) ? CMD_WRITE : CMD_READ;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 10)      len = LEN_W'($urandom_range(MAX_BURST + 1, 15));
        else if (pick < 50) len = LEN_W'(MAX_BURST);
        else                len = LEN_W'($urandom_range(0, MAX_BURST - 1));
        offer_burst(cmd, len, {$urandom, $urandom}, 1'b0, '0);
    endtask

    // result checker
    always @(posedge i_clk) begin
        burst_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: accepted %0b data %h level %0d full %0b",
                             o_accepted, o_read_data, o_level, o_is_full);
            end else begin
                want = pending_results.pop_front();
                if (o_accepted !== want.accepted || o_read_data !== want.read_data ||
                    o_level !== want.level || o_is_full !== want.is_full) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: exp acc %0b data %h level %0d full %0b, got acc %0b data %h level %0d full %0b",
                                 $realtime, want.accepted, want.read_data, want.level,
                                 want.is_full, o_accepted, o_read_data, o_level, o_is_full);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("byte_ring_buffer_burst_tb failed");
        $finish;
    end

    // result side: random holds, plus one long hold so the input backs up
    initial begin : sink
        int   hold;
        logic pressed;
        hold    = 0;
        pressed = 1'b0;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold == 0) begin
                if (!pressed && results_seen >= 150) begin
                    pressed = 1'b1;
                    hold    = 120;
                end else if (!calm && gap_odds > 0 && $urandom_range(0, 9) == 0) begin
                    hold = $urandom_range(1, 17);
                end
            end
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int               caps [PHASES];
        logic [APB_DW-1:0] cfg;
        traffic_t         mode;
        int               p;
        int               b;
        mismatches   = 0;
        results_seen = 0;
        stall_cycles = 0;
        gap_odds     = 4;
        calm         = 1'b0;
        head_ptr     = 0;
        tail_ptr     = 0;
        ring_full    = 1'b0;
        capacity_reg = CAP_RESET;
        caps = '{0, 1, 256, 9, 511, 300, 2, 257, 0, 256};
        caps[8] = $urandom_range(3, 255);
        mode = MODE_FILL;

        i_rst_n      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        i_valid      <= 1'b0;
        i_cmd        <= CMD_WRITE;
        i_length     <= '0;
        i_write_data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (b = 0; b < PLAN_ROWS; b++)
            offer_burst(opening_plan[b].cmd, opening_plan[b].len, opening_plan[b].wdata,
                        opening_plan[b].typed, opening_plan[b].want);

        for (p = 0; p < PHASES; p++) begin
            settle();
            // upper bits are don't-care, keep them noisy
            cfg = $urandom;
            cfg[CAP_W-1:0] = CAP_W'(caps[p]);
            write_capacity(cfg);
            calm = (p == PHASES - 1);
            for (b = 0; b < PHASE_BEATS; b++) begin
                if (b % CHUNK == 0) begin
                    if (b == 0) mode = MODE_FILL;
                    else mode = traffic_t'($urandom_range(0, 2));
                    if (calm) gap_odds = 0;
                    else gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
                end
                random_burst(mode);
            end
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("byte_ring_buffer_burst_tb passed");
        end else begin
            $display("byte_ring_buffer_burst_tb failed");
        end
        $finish;
    end

endmodule
